### sv/fpcd_pkg.sv
// ----------------------------------------------------------------------------
// fpcd_pkg - shared types and constants for the frame pixel distance block
// Word formats, configuration register indexes and the pipelined
// integer-root step.
// ----------------------------------------------------------------------------
package fpcd_pkg;

    localparam int CHAN_W             = 8;
    localparam int NUM_CHAN           = 4;
    localparam int MAX_CHANNELS       = 4;
    localparam int CHAN_LIMIT         = (MAX_CHANNELS < NUM_CHAN) ? MAX_CHANNELS : NUM_CHAN;
    localparam int CU_W               = 3;
    localparam int FP_W               = 22;
    localparam int CFG_IDX_W          = 2;
    localparam int CFG_DATA_W         = FP_W;
    localparam int MAX_PIXELS_DEFAULT = 2097152;
    localparam int FRAME_PIXELS_RESET = 2073600;
    localparam logic [CU_W-1:0] CHANNELS_USED_RESET = 3'd4;

    // squared-difference sum and its root
    localparam int SQ_W            = 2 * CHAN_W;
    localparam int SUM_W           = SQ_W + 2;
    localparam int ROOT_W          = SUM_W / 2;
    localparam int REM_W           = ROOT_W + 3;
    localparam int STEPS_PER_STAGE = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNELS_USED = 2'd0,
        CFG_FRAME_PIXELS  = 2'd1
    } cfg_index_t;

    // input word: chan0 in the low byte
    typedef struct packed {
        logic [CHAN_W-1:0] chan3;
        logic [CHAN_W-1:0] chan2;
        logic [CHAN_W-1:0] chan1;
        logic [CHAN_W-1:0] chan0;
    } pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] distance;
        logic              last_pixel;
    } result_t;

    // digit-by-digit root state, two radicand bits per step
    typedef struct packed {
        logic [SUM_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_t;

    function automatic sqrt_t sqrt_step(input sqrt_t s);
        sqrt_t            r;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        rem_sh = {s.rem[REM_W-3:0], s.rad[SUM_W-1 -: 2]};
        trial  = REM_W'({s.root, 2'b01});
        r.rad  = {s.rad[SUM_W-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            r.rem  = rem_sh - trial;
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = rem_sh;
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic sqrt_t sqrt_stage(input sqrt_t s);
        sqrt_t r;
        r = s;
        for (int i = 0; i < STEPS_PER_STAGE; i++)
        begin
            r = sqrt_step(r);
        end
        return r;
    endfunction

endpackage

### sv/frame_pixel_color_distance.sv
// ----------------------------------------------------------------------------
// frame_pixel_color_distance - per-pixel color distance to the previous frame
// Stores every pixel and returns the saturated integer Euclidean distance
// to the pixel at the same frame position one frame earlier.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock unless a full pipeline is stalled at the
// output, and returns one distance word per pixel from the second frame
// after reset on; the first frame only fills the store and returns nothing.
// The stages are a registered read of the previous-frame RAM, the channel
// squares, their sum, and three stages of three root steps each (the last
// one also saturates and is the output register). The RAM is read and
// written at the same address on the same edge (read-first), so back-to-back
// pixels never wait. A stall at the output backs up stage by stage; empty
// stages keep filling, so the input stalls only once all six stages hold a
// word, and no word is lost or repeated. The store is not cleared after
// reset; it needs no clearing pass because the words read during the first
// frame after reset are dropped. Configuration may only be written while the
// pipeline is empty; both registers take effect on the next pixel.
// ----------------------------------------------------------------------------
module frame_pixel_color_distance #(
    parameter int MAX_PIXELS = fpcd_pkg::MAX_PIXELS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fpcd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fpcd_pkg::CFG_DATA_W-1:0]   cfg_data,
    // pixel input channel
    input  logic                              pixel_valid,
    output logic                              pixel_ready,
    input  fpcd_pkg::pixel_t                  pixel,
    // distance output channel
    output logic                              result_valid,
    input  logic                              result_ready,
    output fpcd_pkg::result_t                 result
);
    import fpcd_pkg::*;

    localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int LIM_W  = ($clog2(MAX_PIXELS + 1) > FP_W) ? $clog2(MAX_PIXELS + 1) : FP_W;
    localparam int RESET_LIMIT = (FRAME_PIXELS_RESET > MAX_PIXELS)
                                 ? MAX_PIXELS : FRAME_PIXELS_RESET;
    localparam logic [ADDR_W-1:0] RESET_LAST_IDX = ADDR_W'(RESET_LIMIT - 1);
    localparam logic [ADDR_W-1:0] MAX_IDX        = ADDR_W'(MAX_PIXELS - 1);

    // ------------------------------------------------------------------
    // Configuration: kept in the form the datapath uses (clamped channel
    // count, index of the last pixel of a frame).
    // ------------------------------------------------------------------
    logic [CU_W-1:0]   chans_reg,    chans_next;
    logic [ADDR_W-1:0] last_idx_reg, last_idx_next;
    logic [CU_W-1:0]   cu_val;
    logic [LIM_W-1:0]  fp_val;
    logic [LIM_W-1:0]  limit;
    logic              cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cu_val    = cfg_data[CU_W-1:0];
    assign fp_val    = LIM_W'(cfg_data[FP_W-1:0]);

    always_comb
    begin
        // a size of zero or past the store depth means the full depth
        if (fp_val == '0 || fp_val > LIM_W'(MAX_PIXELS))
            limit = LIM_W'(MAX_PIXELS);
        else
            limit = fp_val;
    end

    always_comb
    begin
        chans_next    = chans_reg;
        last_idx_next = last_idx_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CHANNELS_USED:
                begin
                    if (cu_val > CU_W'(CHAN_LIMIT))
                        chans_next = CU_W'(CHAN_LIMIT);
                    else
                        chans_next = cu_val;
                end
                CFG_FRAME_PIXELS:
                    last_idx_next = ADDR_W'(limit - LIM_W'(1));
                default:
                begin
                    chans_next    = chans_reg;
                    last_idx_next = last_idx_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chans_reg    <= CHANNELS_USED_RESET;
            last_idx_reg <= RESET_LAST_IDX;
        end
        else
        begin
            chans_reg    <= chans_next;
            last_idx_reg <= last_idx_next;
        end
    end

    // ------------------------------------------------------------------
    // Handshake: each stage loads when it is empty or the next one moves.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
    logic accept;

    assign rdy6        = !v6_reg || result_ready;
    assign rdy5        = !v5_reg || rdy6;
    assign rdy4        = !v4_reg || rdy5;
    assign rdy3        = !v3_reg || rdy4;
    assign rdy2        = !v2_reg || rdy3;
    assign rdy1        = !v1_reg || rdy2;
    assign pixel_ready = rdy1;
    assign accept      = pixel_valid && pixel_ready;

    // ------------------------------------------------------------------
    // Frame position and first-frame flag
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic              have_prev_reg, have_prev_next;
    logic              last;

    // position can pass the end if the frame size was lowered mid-frame
    assign last = (pos_reg >= last_idx_reg);

    always_comb
    begin
        pos_next       = pos_reg;
        have_prev_next = have_prev_reg;
        if (accept)
        begin
            if (last)
            begin
                pos_next       = '0;
                have_prev_next = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            have_prev_reg <= have_prev_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: previous-frame RAM, read-first at the pixel's position
    // ------------------------------------------------------------------
    pixel_t mem [MAX_PIXELS];
    pixel_t old_s1_reg;
    pixel_t cur_s1_reg;
    logic   last_s1_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            old_s1_reg   <= mem[pos_reg];
            mem[pos_reg] <= pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            cur_s1_reg  <= pixel;
            last_s1_reg <= last;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: per-channel squared difference, masked by channel count
    // ------------------------------------------------------------------
    logic [SQ_W-1:0]   sq_s2_reg [NUM_CHAN];
    logic [SQ_W-1:0]   sq_s2_next [NUM_CHAN];
    logic              last_s2_reg;
    logic [CHAN_W-1:0] cur_ch [NUM_CHAN];
    logic [CHAN_W-1:0] old_ch [NUM_CHAN];
    logic [CHAN_W-1:0] adiff  [NUM_CHAN];

    assign cur_ch[0] = cur_s1_reg.chan0;
    assign cur_ch[1] = cur_s1_reg.chan1;
    assign cur_ch[2] = cur_s1_reg.chan2;
    assign cur_ch[3] = cur_s1_reg.chan3;
    assign old_ch[0] = old_s1_reg.chan0;
    assign old_ch[1] = old_s1_reg.chan1;
    assign old_ch[2] = old_s1_reg.chan2;
    assign old_ch[3] = old_s1_reg.chan3;

    always_comb
    begin
        for (int k = 0; k < NUM_CHAN; k++)
        begin
            if (cur_ch[k] >= old_ch[k])
                adiff[k] = cur_ch[k] - old_ch[k];
            else
                adiff[k] = old_ch[k] - cur_ch[k];
            if (CU_W'(k) < chans_reg)
                sq_s2_next[k] = SQ_W'(adiff[k]) * SQ_W'(adiff[k]);
            else
                sq_s2_next[k] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            sq_s2_reg   <= sq_s2_next;
            last_s2_reg <= last_s1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sum of squares
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] sum_s3_reg;
    logic             last_s3_reg;

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            sum_s3_reg  <= SUM_W'(sq_s2_reg[0]) + SUM_W'(sq_s2_reg[1])
                         + SUM_W'(sq_s2_reg[2]) + SUM_W'(sq_s2_reg[3]);
            last_s3_reg <= last_s2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stages 4..6: integer root, three steps per stage; stage 6 saturates
    // into the output register.
    // ------------------------------------------------------------------
    sqrt_t sq_init;
    sqrt_t sq_s4_reg, sq_s5_reg;
    sqrt_t sq_fin;
    logic  last_s4_reg, last_s5_reg;
    result_t result_reg, result_next;

    always_comb
    begin
        sq_init.rad  = sum_s3_reg;
        sq_init.rem  = '0;
        sq_init.root = '0;
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            sq_s4_reg   <= sqrt_stage(sq_init);
            last_s4_reg <= last_s3_reg;
        end
        if (rdy5)
        begin
            sq_s5_reg   <= sqrt_stage(sq_s4_reg);
            last_s5_reg <= last_s4_reg;
        end
    end

    always_comb
    begin
        sq_fin = sqrt_stage(sq_s5_reg);
        if (sq_fin.root > ROOT_W'({CHAN_W{1'b1}}))
            result_next.distance = {CHAN_W{1'b1}};
        else
            result_next.distance = sq_fin.root[CHAN_W-1:0];
        result_next.last_pixel = last_s5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy6)
            result_reg <= result_next;
    end

    assign result       = result_reg;
    assign result_valid = v6_reg;

    // valid bits; first-frame pixels enter as bubbles
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= accept && have_prev_reg;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_pos_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= MAX_IDX)
        else $error("frame position beyond store depth");

    a_result_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> have_prev_reg)
        else $error("result word before a full frame was stored");

    a_wrap_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> (pos_reg == '0 && have_prev_reg))
        else $error("position did not wrap after last pixel");

    a_first_frame_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !have_prev_reg) |=> !v1_reg)
        else $error("first-frame pixel produced a word");

endmodule
